// ===== rtl/r5map_pkg.sv =====
package r5map_pkg;

  // width of every address-like field on the ports
  localparam int FIELD_W = 48;

  // configuration register indexes
  localparam int CFG_IDX_W = 4;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_STRIP_SHIFT = 4'd0;
  localparam cfg_idx_t REG_NUM_DISKS   = 4'd1;

  localparam int CFG_DATA_W = 5;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_data_t STRIP_SHIFT_RST = 5'd3;
  localparam cfg_data_t NUM_DISKS_RST   = 5'd4;
  localparam cfg_data_t STRIP_SHIFT_MAX = 5'd16;
  localparam cfg_data_t NUM_DISKS_MIN   = 5'd3;

  // request and status codes
  localparam logic REQ_READ    = 1'b0;
  localparam logic REQ_WRITE   = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

endpackage

// ===== rtl/raid5_request_mapper.sv =====
// RAID5 request mapper with rotating parity.
// Input channel (in_*): one block request per word, taken when in_valid is
// high and in_stall is low. Result channel (out_*): one word per request,
// taken when out_valid is high and out_stall is low.
// Configuration channel (cfg_*): cfg_ready is always high; index 0 writes
// strip_shift, index 1 writes num_disks, other indexes are dropped. Write
// only while no request is in flight.
// A request runs through one shared restoring divider twice: first the
// block offset (already shifted down by the strip size) by the data disk
// count, then the stripe number by the disk count, one quotient bit per
// cycle over A = min(ADDR_BITS, 48) quotient bits, followed by the base,
// sums and final states; one request is held at a time, so a new one is
// taken only after the previous result has been taken.
// While out_stall is high the result word is held unchanged and in_stall
// stays high.
// Reset loads strip_shift 3, num_disks 4 and closes any stripe assembly.
module raid5_request_mapper #(
  parameter int MAX_DISKS = 16,
  parameter int ADDR_BITS = 48
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  r5map_pkg::cfg_idx_t    cfg_index,
  input  r5map_pkg::cfg_data_t   cfg_data,
  // requests
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_req_type,
  input  logic [47:0]            in_offset_blocks,
  input  logic [16:0]            in_num_blocks,
  input  logic                   in_parent_present,
  input  logic [47:0]            in_parent_offset,
  input  logic [47:0]            in_parent_blocks,
  // results
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_status,
  output logic [3:0]             out_disk_index,
  output logic [47:0]            out_disk_offset,
  output logic [47:0]            out_stripe_number,
  output logic [3:0]             out_parity_disk,
  output logic                   out_stripe_complete
);
  import r5map_pkg::*;

  localparam int AW   = (ADDR_BITS < FIELD_W) ? ADDR_BITS : FIELD_W;
  localparam int DW   = $clog2(MAX_DISKS + 1);
  localparam int CW   = $clog2(AW);
  localparam int CMPW = (DW > 4) ? DW : 4;
  localparam int SBW  = DW + 17;
  localparam int SW   = ((AW > SBW) ? AW : SBW) + 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV1 = 6'b000010,
    S_DIV2 = 6'b000100,
    S_BASE = 6'b001000,
    S_SUMS = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  cfg_data_t strip_shift_r, num_disks_r;

  // request capture
  logic          req_type_r;
  logic [AW-1:0] off_r, poff_r, plen_r;
  logic [16:0]   len_r;
  logic          parent_r;

  // shared divider
  logic [AW-1:0] q_r, q_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r;
  logic [DW:0]   rem_sh;
  logic          step_ge;
  logic [DW-1:0] divisor;

  // intermediate results
  logic [AW-1:0] stripe_r, sstart_r, rdoff_r;
  logic [DW-1:0] didx_r, smod_r, parity_r;
  logic [SW-1:0] psum_r, ssum_r;
  logic          plow_r;

  // assembly state
  logic          open_r;
  logic [AW-1:0] open_stripe_r;
  logic [3:0]    open_pdisk_r;
  logic [3:0]    rcv_cnt_r;

  // effective configuration
  logic [4:0]    sh_eff;
  logic [DW-1:0] n_eff, d_eff;
  logic [AW-1:0] smask;
  logic [16:0]   strip_len;
  logic [SW-1:0] sblocks;

  always_comb begin
    sh_eff = (strip_shift_r > STRIP_SHIFT_MAX) ? STRIP_SHIFT_MAX : strip_shift_r;
    priority if (num_disks_r < NUM_DISKS_MIN) begin
      n_eff = DW'(NUM_DISKS_MIN);
    end else if (32'(num_disks_r) > 32'(MAX_DISKS)) begin
      n_eff = DW'(MAX_DISKS);
    end else begin
      n_eff = DW'(num_disks_r);
    end
    d_eff     = n_eff - DW'(1);
    smask     = ~({AW{1'b1}} << sh_eff);
    strip_len = 17'd1 << sh_eff;
    sblocks   = SW'(d_eff) << sh_eff;
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_shift_r <= STRIP_SHIFT_RST;
      num_disks_r   <= NUM_DISKS_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_STRIP_SHIFT) begin
        strip_shift_r <= cfg_data;
      end else if (cfg_index == REG_NUM_DISKS) begin
        num_disks_r <= cfg_data;
      end
    end
  end

  // one restoring division step per cycle
  always_comb begin
    divisor = (state_r == S_DIV1) ? d_eff : n_eff;
    rem_sh  = {rem_r, q_r[AW-1]};
    step_ge = rem_sh >= {1'b0, divisor};
    rem_nxt = step_ge ? DW'(rem_sh - {1'b0, divisor}) : DW'(rem_sh);
    q_nxt   = {q_r[AW-2:0], step_ge};
  end

  assign in_stall = (state_r != S_IDLE) || out_valid;

  // result build for the final stage
  logic          wr_fail, do_open;
  logic [AW-1:0] eff_stripe;
  logic [3:0]    eff_pdisk, cnt_base, cnt_inc;
  logic          cnt_done;
  logic [3:0]    res_disk;
  logic [AW-1:0] res_doff, res_snum;
  logic [3:0]    res_pdisk;

  always_comb begin
    do_open    = !open_r;
    eff_stripe = do_open ? stripe_r : open_stripe_r;
    eff_pdisk  = do_open ? 4'(parity_r) : open_pdisk_r;
    cnt_base   = do_open ? 4'd0 : rcv_cnt_r;
    cnt_inc    = cnt_base + 4'd1;
    cnt_done   = CMPW'(cnt_inc) >= CMPW'(d_eff);
    wr_fail    = (len_r != strip_len) ||
                 (do_open && (!parent_r || plow_r || (psum_r < ssum_r)));
    if (req_type_r == REQ_WRITE) begin
      res_disk  = (CMPW'(didx_r) >= CMPW'(eff_pdisk)) ? 4'(didx_r + DW'(1)) : 4'(didx_r);
      res_doff  = eff_stripe << sh_eff;
      res_snum  = eff_stripe;
      res_pdisk = eff_pdisk;
    end else begin
      res_disk  = (didx_r < parity_r) ? 4'(didx_r) : 4'(didx_r + DW'(1));
      res_doff  = rdoff_r;
      res_snum  = stripe_r;
      res_pdisk = 4'(parity_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid && !in_stall) state_nxt = S_DIV1;
      S_DIV1: if (cnt_r == '0) state_nxt = S_DIV2;
      S_DIV2: if (cnt_r == '0) state_nxt = S_BASE;
      S_BASE: state_nxt = S_SUMS;
      S_SUMS: state_nxt = S_FIN;
      S_FIN:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      open_r    <= 1'b0;
      open_stripe_r <= '0;
      open_pdisk_r  <= '0;
      rcv_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state_r == S_FIN) begin
        out_valid <= 1'b1;
        if (req_type_r == REQ_WRITE && !wr_fail) begin
          open_stripe_r <= eff_stripe;
          open_pdisk_r  <= eff_pdisk;
          open_r        <= !cnt_done;
          rcv_cnt_r     <= cnt_done ? 4'd0 : cnt_inc;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          req_type_r <= in_req_type;
          off_r      <= in_offset_blocks[AW-1:0];
          len_r      <= in_num_blocks;
          parent_r   <= in_parent_present;
          poff_r     <= in_parent_offset[AW-1:0];
          plen_r     <= in_parent_blocks[AW-1:0];
          q_r        <= in_offset_blocks[AW-1:0] >> sh_eff;
          rem_r      <= '0;
          cnt_r      <= CW'(AW - 1);
        end
      end
      S_DIV1: begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == '0) begin
          // quotient is the stripe, remainder the data strip index
          stripe_r <= q_nxt;
          didx_r   <= rem_nxt;
          q_r      <= q_nxt;
          rem_r    <= '0;
          cnt_r    <= CW'(AW - 1);
        end else begin
          q_r   <= q_nxt;
          rem_r <= rem_nxt;
        end
      end
      S_DIV2: begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == '0) smod_r <= rem_nxt;
      end
      S_BASE: begin
        parity_r <= d_eff - smod_r;
        sstart_r <= off_r - ((AW'(didx_r) << sh_eff) | (off_r & smask));
        rdoff_r  <= (stripe_r << sh_eff) + (off_r & smask);
      end
      S_SUMS: begin
        psum_r <= SW'(poff_r) + SW'(plen_r);
        ssum_r <= SW'(sstart_r) + sblocks;
        plow_r <= poff_r > sstart_r;
      end
      S_FIN: begin
        if (req_type_r == REQ_WRITE && wr_fail) begin
          out_status          <= STATUS_FAIL;
          out_disk_index      <= '0;
          out_disk_offset     <= '0;
          out_stripe_number   <= '0;
          out_parity_disk     <= '0;
          out_stripe_complete <= 1'b0;
        end else begin
          out_status          <= STATUS_OK;
          out_disk_index      <= res_disk;
          out_disk_offset     <= FIELD_W'(res_doff);
          out_stripe_number   <= FIELD_W'(res_snum);
          out_parity_disk     <= res_pdisk;
          out_stripe_complete <= (req_type_r == REQ_WRITE) && cnt_done;
        end
      end
      default: ;
    endcase
  end

  a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state register not one-hot");

  a_busy_while_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("request taken while result pending");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_FAIL) |->
      (out_disk_index == '0 && out_disk_offset == '0 && out_stripe_number == '0 &&
       out_parity_disk == '0 && !out_stripe_complete))
    else $error("failed word carries data");

  a_complete_closes: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && out_stripe_complete |-> !open_r && rcv_cnt_r == 4'd0)
    else $error("stripe assembly still open after completion");

endmodule
